@@ src/mfe_pkg.sv @@
// Package for the Manchester frame encoder with CRC-8 framing.
// Holds shared constants, the queue entry type, the sequencer state type and
// the coding and checksum functions. No dependencies.
package mfe_pkg;

    // Frame geometry
    localparam int PAYLOAD_BYTES = 8;
    localparam int POS_W         = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam bit SINGLE_BYTE   = (PAYLOAD_BYTES == 1);

    // Queue between front and back; depth must be a power of two for pointer wrap
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes and reset values
    localparam int CFG_ADDR_W = 2;
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_PREAMBLE = 2'd0,
        CFG_START    = 2'd1,
        CFG_POLY     = 2'd2
    } cfg_index_t;

    localparam logic [7:0] PREAMBLE_RESET = 8'h00;
    localparam logic [7:0] START_RESET    = 8'h09;
    localparam logic [7:0] POLY_RESET     = 8'hB3;

    // One classified payload byte waiting for the back end
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] crc;
        logic       first;
        logic       last;
    } entry_t;

    // Back-end word sequencer
    typedef enum logic [1:0] {
        PH_HEAD,
        PH_START,
        PH_DATA,
        PH_CRC
    } phase_t;

    // Code one byte as 16 chips, MSB first: 1 -> 10, 0 -> 01
    function automatic logic [15:0] manchester(input logic [7:0] b);
        logic [15:0] w;
        w = '0;
        for (int i = 0; i < 8; i++) begin
            w[2*i +: 2] = b[i] ? 2'b10 : 2'b01;
        end
        return w;
    endfunction

    // MSB-first CRC-8 update over one byte
    function automatic logic [7:0] crc_update(input logic [7:0] crc,
                                              input logic [7:0] b,
                                              input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

@@ src/manchester_frame_encoder_crc8_unit.sv @@
// A byte is first written into the queue; its first word then goes to the output
// register. One output word per cycle while the queue holds an entry and m_ready
// is high; a byte gives 1 to 3 words (3 first, 2 last), 11 words per frame.
// Input accepts one byte per cycle while the 2-entry queue has room.
// Reset (aresetn low, synchronous) clears frame position, CRC, queue and output
// valid, and loads the configuration registers with their default values.
module manchester_frame_encoder_crc8_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [mfe_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [7:0]                     cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_payload_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [15:0]                    m_chips,
    output logic [7:0]                     m_raw_byte,
    output logic                           m_frame_end
);

    logic [7:0]      preamble_reg, start_reg, poly_reg;
    logic            q_push, q_pop, q_empty, q_full;
    mfe_pkg::entry_t q_in, q_head;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            preamble_reg <= mfe_pkg::PREAMBLE_RESET;
            start_reg    <= mfe_pkg::START_RESET;
            poly_reg     <= mfe_pkg::POLY_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                mfe_pkg::CFG_PREAMBLE: preamble_reg <= cfg_wdata;
                mfe_pkg::CFG_START:    start_reg    <= cfg_wdata;
                mfe_pkg::CFG_POLY:     poly_reg     <= cfg_wdata;
                default:               ;
            endcase
        end
    end

    mfe_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload_byte (s_payload_byte),
        .crc_poly       (poly_reg),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_entry        (q_in)
    );

    mfe_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty),
        .full       (q_full)
    );

    mfe_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (q_head),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .preamble_byte (preamble_reg),
        .start_byte    (start_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_chips       (m_chips),
        .m_raw_byte    (m_raw_byte),
        .m_frame_end   (m_frame_end)
    );

endmodule

@@ src/mfe_front.sv @@
// Front end: accepts payload bytes, tracks frame position and running CRC.
// Pushes one classified entry per byte into the queue. Uses mfe_pkg.
module mfe_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_payload_byte,
    input  logic [7:0]           crc_poly,
    input  logic                 q_full,
    output logic                 q_push,
    output mfe_pkg::entry_t      q_entry
);

    logic [mfe_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [7:0]                crc_reg, crc_next;
    logic                      is_first, is_last;
    logic [7:0]                crc_new;

    // Accept while the queue has room
    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    // Classify the byte and fold it into the CRC
    assign is_first = (pos_reg == '0);
    assign is_last  = (pos_reg == mfe_pkg::POS_W'(mfe_pkg::PAYLOAD_BYTES - 1));
    assign crc_new  = mfe_pkg::crc_update(crc_reg, s_payload_byte, crc_poly);

    assign q_entry.data  = s_payload_byte;
    assign q_entry.crc   = crc_new;
    assign q_entry.first = is_first;
    assign q_entry.last  = is_last;

    // Advance position, wrap and clear the CRC at frame end
    always_comb begin
        pos_next = pos_reg;
        crc_next = crc_reg;
        if (q_push) begin
            if (is_last) begin
                pos_next = '0;
                crc_next = '0;
            end else begin
                pos_next = pos_reg + 1'b1;
                crc_next = crc_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            crc_reg <= '0;
        end else begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
        end
    end

endmodule

@@ src/mfe_queue.sv @@
// Short queue of classified entries between front and back ends.
// Depth and pointer widths come from mfe_pkg.
module mfe_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  mfe_pkg::entry_t push_entry,
    input  logic            pop,
    output mfe_pkg::entry_t head,
    output logic            empty,
    output logic            full
);

    mfe_pkg::entry_t                mem [mfe_pkg::QUEUE_DEPTH];
    logic [mfe_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [mfe_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [mfe_pkg::QCNT_W-1:0]     count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == mfe_pkg::QCNT_W'(mfe_pkg::QUEUE_DEPTH));
    assign head  = mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ src/mfe_back.sv @@
// Back end: walks each queued entry through its words (preamble, start,
// payload, CRC) and loads them into the output register. Uses mfe_pkg.
module mfe_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  mfe_pkg::entry_t head,
    input  logic            q_empty,
    output logic            q_pop,
    input  logic [7:0]      preamble_byte,
    input  logic [7:0]      start_byte,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [15:0]     m_chips,
    output logic [7:0]      m_raw_byte,
    output logic            m_frame_end
);

    mfe_pkg::phase_t phase_reg, phase_next;
    logic            m_valid_reg, m_valid_next;
    logic [15:0]     chips_reg;
    logic [7:0]      raw_reg;
    logic            end_reg;
    logic            load;
    logic [7:0]      sel_byte;
    logic            sel_end;

    // Emit a word when an entry waits and the output register frees up
    assign load = !q_empty && (!m_valid_reg || m_ready);

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        if (load) begin
            unique case (phase_reg)
                mfe_pkg::PH_HEAD: begin
                    if (head.first && !mfe_pkg::SINGLE_BYTE) begin
                        phase_next = mfe_pkg::PH_START;
                    end else if (head.first) begin
                        phase_next = mfe_pkg::PH_DATA;
                    end else if (head.last) begin
                        phase_next = mfe_pkg::PH_CRC;
                    end else begin
                        phase_next = mfe_pkg::PH_HEAD;
                    end
                end
                mfe_pkg::PH_START: phase_next = mfe_pkg::PH_DATA;
                mfe_pkg::PH_DATA:
                    phase_next = head.last ? mfe_pkg::PH_CRC : mfe_pkg::PH_HEAD;
                mfe_pkg::PH_CRC:   phase_next = mfe_pkg::PH_HEAD;
                default:           phase_next = mfe_pkg::PH_HEAD;
            endcase
        end
    end

    // Word selection and queue pop
    always_comb begin
        sel_byte = head.data;
        sel_end  = 1'b0;
        q_pop    = 1'b0;
        unique case (phase_reg)
            mfe_pkg::PH_HEAD: begin
                if (head.first && !mfe_pkg::SINGLE_BYTE) begin
                    sel_byte = preamble_byte;
                end else if (head.first) begin
                    sel_byte = start_byte;
                end else begin
                    q_pop = load && !head.last;
                end
            end
            mfe_pkg::PH_START: sel_byte = start_byte;
            mfe_pkg::PH_DATA:  q_pop = load && !head.last;
            mfe_pkg::PH_CRC: begin
                sel_byte = head.crc;
                sel_end  = 1'b1;
                q_pop    = load;
            end
            default: sel_byte = head.data;
        endcase
    end

    // Output register: hold until transfer, reload behind it
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= mfe_pkg::PH_HEAD;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            chips_reg <= mfe_pkg::manchester(sel_byte);
            raw_reg   <= sel_byte;
            end_reg   <= sel_end;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_chips     = chips_reg;
    assign m_raw_byte  = raw_reg;
    assign m_frame_end = end_reg;

    // Checks
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    a_mid_entry_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == mfe_pkg::PH_START || phase_reg == mfe_pkg::PH_CRC) |-> !q_empty)
        else $error("entry left the queue before its words were sent");

    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_valid_reg)
        else $error("loaded word not presented");

    a_crc_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && phase_reg == mfe_pkg::PH_CRC) |=> (end_reg && phase_reg == mfe_pkg::PH_HEAD))
        else $error("CRC word not marked as frame end");

endmodule

@@ tb/manchester_frame_encoder_crc8_unit_tb.sv @@
// Self-checking testbench for manchester_frame_encoder_crc8_unit.
// Depends on mfe_pkg for the register indexes, reset values and frame size.
// A scoreboard class predicts the coded words; tasks drive the input, a process the ready.
module manchester_frame_encoder_crc8_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Spare register index: writes to it must be ignored
    localparam logic [mfe_pkg::CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;

    localparam int PHASES        = 7;
    localparam int LONG_HOLD     = 80;
    localparam int SETTLE_CYCLES = 8;
    // Roughly 270 bytes, up to 3 words each, each behind the longest stall, plus
    // sender gaps and the long hold-off, taken several times over
    localparam int CYCLE_LIMIT   = 200000;

    // One expected coded word on the result channel
    typedef struct packed {
        logic [15:0] chips;
        logic [7:0]  raw;
        logic        frame_end;
    } coded_word_t;

    // Predicts the coded words of each payload byte and checks them in order
    class frame_scoreboard;
        logic [7:0]  preamble;
        logic [7:0]  start_mark;
        logic [7:0]  poly;
        logic [7:0]  crc_acc;
        int unsigned position;
        coded_word_t due_words[$];
        int unsigned errors;
        int unsigned words_seen;
        int unsigned frames_closed;

        function new();
            preamble      = mfe_pkg::PREAMBLE_RESET;
            start_mark    = mfe_pkg::START_RESET;
            poly          = mfe_pkg::POLY_RESET;
            crc_acc       = '0;
            position      = 0;
            errors        = 0;
            words_seen    = 0;
            frames_closed = 0;
        endfunction

        // Two chips per bit, MSB first: 1 gives 10, 0 gives 01
        function logic [15:0] chip_code(input logic [7:0] b);
            logic [15:0] w;
            w = '0;
            for (int i = 7; i >= 0; i--) begin
                w = {w[13:0], b[i], ~b[i]};
            end
            return w;
        endfunction

        // Shift one byte through the MSB-first CRC with the current polynomial
        function logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
            logic [7:0] c;
            c = acc ^ b;
            for (int i = 0; i < 8; i++) begin
                if (c[7]) c = {c[6:0], 1'b0} ^ poly;
                else      c = {c[6:0], 1'b0};
            end
            return c;
        endfunction

        function void push_word(input logic [7:0] b, input logic fe);
            coded_word_t w;
            w.chips     = chip_code(b);
            w.raw       = b;
            w.frame_end = fe;
            due_words.push_back(w);
        endfunction

        function void set_reg(input logic [mfe_pkg::CFG_ADDR_W-1:0] idx,
                              input logic [7:0] val);
            case (idx)
                mfe_pkg::CFG_PREAMBLE: preamble = val;
                mfe_pkg::CFG_START:    start_mark = val;
                mfe_pkg::CFG_POLY:     poly = val;
                default:               ;
            endcase
        endfunction

        // Queue the words one accepted payload byte produces
        function void note_byte(input logic [7:0] b);
            bit opening;
            bit closing;
            opening = (position == 0);
            closing = (position + 1 >= mfe_pkg::PAYLOAD_BYTES);
            if (opening) begin
                crc_acc = '0;
                // a one-byte frame has no room for the preamble word
                if (!closing) push_word(preamble, 1'b0);
                push_word(start_mark, 1'b0);
            end
            push_word(b, 1'b0);
            crc_acc = crc8_step(crc_acc, b);
            if (closing) begin
                push_word(crc_acc, 1'b1);
                position = 0;
                crc_acc  = '0;
            end else begin
                position++;
            end
        endfunction

        function void check_word(input logic [15:0] chips, input logic [7:0] raw,
                                 input logic fe);
            coded_word_t want;
            words_seen++;
            if (due_words.size() == 0) begin
                errors++;
                $display("%0t: unexpected word chips=%h raw=%h frame_end=%b",
                         $time, chips, raw, fe);
                return;
            end
            want = due_words.pop_front();
            if (chips !== want.chips) begin
                errors++;
                $display("%0t: chips mismatch expected %h actual %h", $time, want.chips, chips);
            end
            if (raw !== want.raw) begin
                errors++;
                $display("%0t: raw_byte mismatch expected %h actual %h", $time, want.raw, raw);
            end
            if (fe !== want.frame_end) begin
                errors++;
                $display("%0t: frame_end mismatch expected %b actual %b",
                         $time, want.frame_end, fe);
            end
            if (want.frame_end) frames_closed++;
        endfunction

        function int pending();
            return due_words.size();
        endfunction
    endclass

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_wr_en;
    logic [mfe_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [7:0]                     cfg_wdata;
    logic                           s_valid;
    logic                           s_ready;
    logic [7:0]                     s_payload_byte;
    logic                           m_valid;
    logic                           m_ready;
    logic [15:0]                    m_chips;
    logic [7:0]                     m_raw_byte;
    logic                           m_frame_end;

    frame_scoreboard sb = new();

    int unsigned bytes_sent    = 0;
    int unsigned reg_writes    = 0;
    int unsigned cycle_count   = 0;
    int          sink_idle_pct = 0;
    int          src_idle_pct  = 0;
    bit          calm          = 1'b0;
    bit          stall_request = 1'b0;

    manchester_frame_encoder_crc8_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload_byte (s_payload_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_chips        (m_chips),
        .m_raw_byte     (m_raw_byte),
        .m_frame_end    (m_frame_end)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Stop a hung run
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles, %0d words still due",
                 $time, cycle_count, sb.pending());
        $display("manchester_frame_encoder_crc8_unit verification failed");
        $finish;
    end

    // Check each result transfer, then pick the next ready level
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) sb.check_word(m_chips, m_raw_byte, m_frame_end);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_request) begin
                // long hold-off so the block fills and stalls its input
                stall_request = 1'b0;
                hold_left     = LONG_HOLD - 1;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 99) < sink_idle_pct) begin
                hold_left = $urandom_range(1, 18) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one byte and hold it until the transfer
    task automatic send_byte(input logic [7:0] b);
        s_valid        <= 1'b1;
        s_payload_byte <= b;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic idle_source(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // Drop valid and wait until every due word has come out
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Leaves the enable high; call end_writes after the last write of a group
    task automatic write_reg(input logic [mfe_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
        reg_writes++;
    endtask

    task automatic end_writes();
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly uniform, with the extremes weighted up
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin : stimulus
        logic [7:0] plain_frame [8];
        logic [7:0] dense_frame [8];
        int         n;

        plain_frame = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55, 8'h7F, 8'hFE};
        dense_frame = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};

        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_addr       = '0;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_payload_byte = '0;
        m_ready        = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: one frame with the reset register values
        foreach (plain_frame[i]) send_byte(plain_frame[i]);
        settle();

        // Directed: extreme register values, plus a write to the spare index
        write_reg(mfe_pkg::CFG_PREAMBLE, 8'hFF);
        write_reg(mfe_pkg::CFG_START, 8'h00);
        write_reg(mfe_pkg::CFG_POLY, 8'hFF);
        write_reg(CFG_SPARE, 8'h5A);
        end_writes();
        foreach (dense_frame[i]) send_byte(dense_frame[i]);
        settle();

        // Directed: change every register in the middle of a frame
        for (int i = 0; i < 3; i++) send_byte(pick_byte());
        settle();
        write_reg(mfe_pkg::CFG_POLY, 8'h00);
        write_reg(mfe_pkg::CFG_PREAMBLE, 8'h00);
        write_reg(mfe_pkg::CFG_START, 8'hFF);
        end_writes();
        for (int i = 0; i < 5; i++) send_byte(pick_byte());

        // Random phases: new registers while idle, often mid-frame
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            if ($urandom_range(0, 1)) write_reg(mfe_pkg::CFG_PREAMBLE, pick_byte());
            if ($urandom_range(0, 1)) write_reg(mfe_pkg::CFG_START, pick_byte());
            if ($urandom_range(0, 2) != 0) write_reg(mfe_pkg::CFG_POLY, pick_byte());
            if ($urandom_range(0, 5) == 0) write_reg(CFG_SPARE, pick_byte());
            end_writes();

            if (ph == 0) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end else if (ph == PHASES - 1) begin
                calm = 1'b1;
            end else begin
                src_idle_pct  = $urandom_range(5, 40);
                sink_idle_pct = $urandom_range(5, 40);
            end

            // back-to-back bytes against a long receiver hold-off
            if (ph == 2) begin
                src_idle_pct  = 0;
                stall_request = 1'b1;
            end

            n = $urandom_range(28, 40);
            for (int k = 0; k < n; k++) begin
                // pause the sender once until the block has drained
                if (ph == 4 && k == n / 2) settle();
                if (!calm && src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct)
                    idle_source($urandom_range(1, 18));
                send_byte(pick_byte());
            end
        end

        settle();

        $display("Covered %0d payload bytes, %0d coded words, %0d closed frames,",
                 bytes_sent, sb.words_seen, sb.frames_closed);
        $display("%0d register writes incl. mid-frame and spare-index, with back-pressure",
                 reg_writes);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("manchester_frame_encoder_crc8_unit verification clean");
        end else begin
            $display("manchester_frame_encoder_crc8_unit verification failed");
        end
        $finish;
    end

endmodule
